[design/ddfe_pkg.sv]
// Shared types and constants for the frame-to-eRPM block.
`timescale 1ns / 1ps
`default_nettype none

package ddfe_pkg;

  localparam logic [7:0] START_MARK = 8'h02;
  localparam logic [7:0] END_MARK   = 8'h03;

  localparam logic REQ_TICK = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] WATCHDOG_RST  = 16'd500;
  localparam logic [15:0] KEEPALIVE_RST = 16'd100;
  localparam logic [31:0] GAIN_LIN_RST  = 32'd2086075695;
  localparam logic [31:0] GAIN_TURN_RST = 32'd1043037848;

  typedef enum logic [1:0] {
    CMD_DRIVE = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_KEEP  = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    CFG_WATCHDOG  = 2'd0,
    CFG_KEEPALIVE = 2'd1,
    CFG_GAIN_LIN  = 2'd2,
    CFG_GAIN_TURN = 2'd3
  } cfg_reg_t;

  // one command waiting for the arithmetic back end
  typedef struct packed {
    cmd_kind_t   kind;
    logic        led;
    logic [31:0] v_bits;
    logic [31:0] w_bits;
  } job_t;

endpackage

`default_nettype wire

[design/ddfe_in_if.sv]
// Request channel: received byte or millisecond tick.
`timescale 1ns / 1ps
`default_nettype none

interface ddfe_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/ddfe_out_if.sv]
// Result channel: motor command with wheel eRPM and LED level.
`timescale 1ns / 1ps
`default_nettype none

interface ddfe_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd_kind;
  logic signed [31:0] left_erpm;
  logic signed [31:0] right_erpm;
  logic               led_on;

  modport source (output valid, output cmd_kind, output left_erpm, output right_erpm,
                  output led_on, input ready);
  modport sink   (input valid, input cmd_kind, input left_erpm, input right_erpm,
                  input led_on, output ready);
endinterface

`default_nettype wire

[design/ddfe_front.sv]
// Front end: frame parser, watchdog and keepalive timers, command classification.
`timescale 1ns / 1ps
`default_nettype none

module ddfe_front #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ddfe_in_if.sink            in_ch,
  input  wire logic          q_full,
  input  wire logic [15:0]   watchdog_timeout_ms,
  input  wire logic [15:0]   keepalive_period_ms,
  output logic               push,
  output ddfe_pkg::job_t     push_job
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_END     = 2'd2
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic [7:0]            pay_r [8];
  logic [7:0]            pay_nxt [8];
  logic [TIMER_BITS-1:0] fr_r, fr_nxt, fr_inc;
  logic [TIMER_BITS-1:0] ka_r, ka_nxt, ka_inc;
  logic                  stopped_r, stopped_nxt;
  logic                  led_r, led_nxt;
  logic                  accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign fr_inc = (fr_r != '1) ? fr_r + 1'b1 : fr_r;
  assign ka_inc = (ka_r != '1) ? ka_r + 1'b1 : ka_r;

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    pay_nxt     = pay_r;
    fr_nxt      = fr_r;
    ka_nxt      = ka_r;
    stopped_nxt = stopped_r;
    led_nxt     = led_r;
    push        = 1'b0;
    push_job.kind   = ddfe_pkg::CMD_DRIVE;
    push_job.led    = led_r;
    push_job.v_bits = {pay_r[3], pay_r[2], pay_r[1], pay_r[0]};
    push_job.w_bits = {pay_r[7], pay_r[6], pay_r[5], pay_r[4]};
    if (accept) begin
      if (in_ch.req_type != ddfe_pkg::REQ_TICK) begin
        case (phase_r)
          PH_PAYLOAD: begin
            pay_nxt[cnt_r] = in_ch.rx_byte;
            cnt_nxt        = cnt_r + 3'd1;
            if (cnt_r == 3'd7) begin
              phase_nxt = PH_END;
            end
          end
          PH_END: begin
            phase_nxt = PH_HUNT;
            if (in_ch.rx_byte == ddfe_pkg::END_MARK) begin
              fr_nxt        = '0;
              stopped_nxt   = 1'b0;
              led_nxt       = 1'b1;
              push          = 1'b1;
              push_job.kind = ddfe_pkg::CMD_DRIVE;
              push_job.led  = 1'b1;
            end
          end
          default: begin
            if (in_ch.rx_byte == ddfe_pkg::START_MARK) begin
              phase_nxt = PH_PAYLOAD;
              cnt_nxt   = 3'd0;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        endcase
      end else begin
        fr_nxt = fr_inc;
        ka_nxt = ka_inc;
        if (!stopped_r && (CW'(fr_inc) >= CW'(watchdog_timeout_ms))) begin
          stopped_nxt   = 1'b1;
          led_nxt       = 1'b0;
          push          = 1'b1;
          push_job.kind = ddfe_pkg::CMD_STOP;
          push_job.led  = 1'b0;
        end else if (!stopped_r && (CW'(ka_inc) > CW'(keepalive_period_ms))) begin
          ka_nxt        = '0;
          push          = 1'b1;
          push_job.kind = ddfe_pkg::CMD_KEEP;
          push_job.led  = led_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      cnt_r     <= 3'd0;
      fr_r      <= '0;
      ka_r      <= '0;
      stopped_r <= 1'b1;
      led_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      fr_r      <= fr_nxt;
      ka_r      <= ka_nxt;
      stopped_r <= stopped_nxt;
      led_r     <= led_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // LED is lit exactly while the motors run
  a_led_vs_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !led_r)
    else $error("LED lit while stopped");

  // a drive request only leaves the end-marker phase
  a_drive_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_job.kind == ddfe_pkg::CMD_DRIVE) |-> (phase_r == PH_END && cnt_r == 3'd0))
    else $error("drive pushed outside end phase");
`endif

endmodule

`default_nettype wire

[design/ddfe_queue.sv]
// Short request queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module ddfe_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ddfe_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                q_valid,
  output logic                q_full,
  output ddfe_pkg::job_t      q_job
);

  ddfe_pkg::job_t                 mem_r [ddfe_pkg::QUEUE_DEPTH];
  logic [ddfe_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [ddfe_pkg::QPTR_W:0]      count_r;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (ddfe_pkg::QPTR_W + 1)'(ddfe_pkg::QUEUE_DEPTH));
  assign q_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_full || pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue underflow");
`endif

endmodule

`default_nettype wire

[design/ddfe_back.sv]
// Back end: float to Q16.16, gain multiply, wheel mix, round and saturate.
`timescale 1ns / 1ps
`default_nettype none

module ddfe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire ddfe_pkg::job_t q_job,
  output logic                pop,
  input  wire logic [31:0]    gain_linear,
  input  wire logic [31:0]    gain_turn,
  ddfe_out_if.source          out_ch
);

  // binary32 to Q16.16 sign/magnitude, round half away, saturating; NaN gives 0
  function automatic logic [32:0] f2q(input logic [31:0] bits);
    logic [7:0]  e;
    logic [23:0] m;
    logic [40:0] r;
    logic [40:0] ext;
    logic [4:0]  k;
    logic        neg;
    neg = bits[31];
    e   = bits[30:23];
    m   = {1'b1, bits[22:0]};
    r   = '0;
    ext = '0;
    k   = '0;
    if (e == 8'hFF) begin
      if (bits[22:0] != 23'd0) begin
        neg = 1'b0;
      end else begin
        r = 41'hFFFF_FFFF;
      end
    end else if (e == 8'd0) begin
      r = '0;
    end else if (e > 8'd150) begin
      r = 41'hFFFF_FFFF;
    end else if (e >= 8'd134) begin
      r = 41'(m) << 5'(e - 8'd134);
    end else if (e < 8'd109) begin
      r = '0;
    end else begin
      k   = 5'(8'd134 - e);
      ext = 41'(m) + (41'd1 << (k - 5'd1));
      r   = ext >> k;
    end
    if (neg) begin
      if (r > 41'h8000_0000) r = 41'h8000_0000;
    end else if (r > 41'h7FFF_FFFF) begin
      r = 41'h7FFF_FFFF;
    end
    return {neg, r[31:0]};
  endfunction

  // signed-magnitude add of two Q32.32 terms
  function automatic logic [64:0] sm_add(input logic na, input logic [63:0] a,
                                         input logic nb, input logic [63:0] b);
    logic        n;
    logic [63:0] mg;
    if (na == nb) begin
      n  = na;
      mg = a + b;
    end else if (a >= b) begin
      n  = na;
      mg = a - b;
    end else begin
      n  = nb;
      mg = b - a;
    end
    return {n, mg};
  endfunction

  function automatic logic [31:0] round_sat(input logic n, input logic [63:0] mg);
    logic [64:0] s;
    logic [32:0] r;
    s = 65'(mg) + 65'h8000_0000;
    r = s[64:32];
    if (n) begin
      if (r > 33'h8000_0000) r = 33'h8000_0000;
      return 32'(33'd0 - r);
    end
    if (r > 33'h7FFF_FFFF) r = 33'h7FFF_FFFF;
    return r[31:0];
  endfunction

  logic                v0_r, v1_r, v2_r, v3_r;
  ddfe_pkg::cmd_kind_t k0_r, k1_r, k2_r, k3_r;
  logic                l0_r, l1_r, l2_r, l3_r;
  logic                vn0_r, wn0_r, vn1_r, wn1_r;
  logic [31:0]         vm0_r, wm0_r;
  logic [63:0]         pl1_r, pt1_r;
  logic [64:0]         lsum2_r, rsum2_r;
  logic [31:0]         left3_r, right3_r;
  logic [32:0]         vq, wq;
  logic                adv;

  assign adv = !v3_r || out_ch.ready;
  assign pop = adv && q_valid;
  assign vq  = f2q(q_job.v_bits);
  assign wq  = f2q(q_job.w_bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= q_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k0_r    <= q_job.kind;
      l0_r    <= q_job.led;
      vn0_r   <= vq[32];
      vm0_r   <= vq[31:0];
      wn0_r   <= wq[32];
      wm0_r   <= wq[31:0];

      k1_r    <= k0_r;
      l1_r    <= l0_r;
      vn1_r   <= vn0_r;
      wn1_r   <= wn0_r;
      pl1_r   <= gain_linear * vm0_r;
      pt1_r   <= gain_turn * wm0_r;

      k2_r    <= k1_r;
      l2_r    <= l1_r;
      lsum2_r <= sm_add(vn1_r, pl1_r, !wn1_r, pt1_r);
      rsum2_r <= sm_add(vn1_r, pl1_r, wn1_r, pt1_r);

      k3_r    <= k2_r;
      l3_r    <= l2_r;
      if (k2_r == ddfe_pkg::CMD_DRIVE) begin
        left3_r  <= round_sat(lsum2_r[64], lsum2_r[63:0]);
        right3_r <= round_sat(rsum2_r[64], rsum2_r[63:0]);
      end else begin
        left3_r  <= 32'd0;
        right3_r <= 32'd0;
      end
    end
  end

  assign out_ch.valid      = v3_r;
  assign out_ch.cmd_kind   = k3_r;
  assign out_ch.left_erpm  = left3_r;
  assign out_ch.right_erpm = right3_r;
  assign out_ch.led_on     = l3_r;

`ifndef NO_ASSERTIONS
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && k3_r != ddfe_pkg::CMD_DRIVE) |-> (left3_r == 32'd0 && right3_r == 32'd0))
    else $error("non-drive command carries eRPM");

  a_led_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && (k3_r == ddfe_pkg::CMD_DRIVE || k3_r == ddfe_pkg::CMD_STOP)) |->
      (l3_r == (k3_r == ddfe_pkg::CMD_DRIVE)))
    else $error("LED level disagrees with command");
`endif

endmodule

`default_nettype wire

[design/diff_drive_frame_to_erpm.sv]
// Top level: configuration registers, front end, request queue and back end.
// Throughput: one request per cycle while the queue is not full; a 4-entry
// queue decouples the parser from the 4-stage arithmetic pipeline, which stalls
// as a whole on output back-pressure.
// Reset: synchronous, active low; parser hunts, timers clear, motors stopped,
// LED off, queue and pipeline empty, registers take their default values.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_frame_to_erpm #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ddfe_in_if.sink          in_ch,
  ddfe_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [15:0]    watchdog_r;
  logic [15:0]    keepalive_r;
  logic [31:0]    gain_lin_r;
  logic [31:0]    gain_turn_r;
  logic           push, pop, q_valid, q_full;
  ddfe_pkg::job_t push_job, q_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watchdog_r  <= ddfe_pkg::WATCHDOG_RST;
      keepalive_r <= ddfe_pkg::KEEPALIVE_RST;
      gain_lin_r  <= ddfe_pkg::GAIN_LIN_RST;
      gain_turn_r <= ddfe_pkg::GAIN_TURN_RST;
    end else if (cfg_we) begin
      case (ddfe_pkg::cfg_reg_t'(cfg_index))
        ddfe_pkg::CFG_WATCHDOG:  watchdog_r  <= cfg_wdata[15:0];
        ddfe_pkg::CFG_KEEPALIVE: keepalive_r <= cfg_wdata[15:0];
        ddfe_pkg::CFG_GAIN_LIN:  gain_lin_r  <= cfg_wdata;
        ddfe_pkg::CFG_GAIN_TURN: gain_turn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ddfe_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ch               (in_ch),
    .q_full              (q_full),
    .watchdog_timeout_ms (watchdog_r),
    .keepalive_period_ms (keepalive_r),
    .push                (push),
    .push_job            (push_job)
  );

  ddfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  ddfe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .pop         (pop),
    .gain_linear (gain_lin_r),
    .gain_turn   (gain_turn_r),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
